// ===== rtl/core/spc_pkg.sv =====
`default_nettype none

package spc_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int INDEX_W         = 16;
    localparam int TAG_W           = 8;
    localparam int IN_DATA_W       = 24;
    localparam int OUT_DATA_W      = 48;

    localparam logic [INDEX_W-1:0] RESYNC_RESET = 16'hFFFF;

    localparam logic SRC_MASTER = 1'b0;
    localparam logic SRC_SLAVE  = 1'b1;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/stereo_frame_pairer_unit.sv =====
// Stereo frame pairer: matches master and slave camera frames by frame index.
// Input stream s_axis carries one arriving frame per request: tuser selects
// the camera (0 master, 1 slave), tdata holds the frame index and buffer tag.
// Output stream m_axis carries one request per pair found: tags, common index
// and the drop count since the previous pair; tuser flags the first pair.
// The resync period register is written through i_cfg_wr_en/i_cfg_wr_data;
// the user must write it only while the block is idle; no check enforces it.
// Each camera queue is a row of cells. After a frame is accepted, a scan copy
// of the master row is loaded and shifted past the slave row, one master entry
// per cycle, compared against all slave cells at once. An arrival that makes
// no pair holds the input until the scan has passed every master entry; one
// that pairs master entry m with slave entry s holds it until both rows have
// shifted out the consumed m + 1 and s + 1 entries, one cell per cycle.
// A found pair waits in the scan stage while the output register is still
// occupied; the input is not ready again until that pair has been stored.
// Reset empties both queues, forgets the previous pair and sets the resync
// period to 65535; queue contents themselves are not cleared.

`default_nettype none

module stereo_frame_pairer_unit #(
    parameter int QUEUE_DEPTH = spc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [spc_pkg::INDEX_W-1:0]         i_cfg_wr_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] frame_index, [23:16] frame_tag
    input  wire  [spc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] source
    input  wire                                 s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [7:0] master_tag, [15:8] slave_tag, [31:16] pair_index,
    // [47:32] dropped_frames
    output logic [spc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] first_pair
    output logic                                m_axis_tuser
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int IW = spc_pkg::INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DROP
    } t_state;

    t_state                       r_state,      n_state;
    logic [IW-1:0]                r_period,     n_period;
    logic [IW-1:0]                r_prev_index, n_prev_index;
    logic                         r_prev_valid, n_prev_valid;
    logic [CW-1:0]                r_m,          n_m;
    logic [CW-1:0]                r_drop_m,     n_drop_m;
    logic [CW-1:0]                r_drop_s,     n_drop_s;
    logic                         r_out_valid,  n_out_valid;
    logic [spc_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                         r_out_first,  n_out_first;
    spc_pkg::t_entry              r_scan [QUEUE_DEPTH];

    spc_pkg::t_entry              in_entry;
    spc_pkg::t_entry              m_entries [QUEUE_DEPTH];
    spc_pkg::t_entry              s_entries [QUEUE_DEPTH];
    logic [CW-1:0]                m_count;
    logic [CW-1:0]                s_count;
    logic                         accept;
    logic                         m_drop;
    logic                         s_drop;
    logic                         s_hit;
    logic [SW-1:0]                s_sel;
    logic [spc_pkg::TAG_W-1:0]    s_tag;
    logic [IW:0]                  expected_wide;
    logic [IW-1:0]                expected;
    logic [IW-1:0]                dropped;
    logic                         out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_entry.index = s_axis_tdata[15:0];
    assign in_entry.tag   = s_axis_tdata[23:16];
    assign m_drop = (r_state == S_DROP) && (r_drop_m != '0);
    assign s_drop = (r_state == S_DROP) && (r_drop_s != '0);

    spc_queue #(.DEPTH(QUEUE_DEPTH)) u_master_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (accept && (s_axis_tuser == spc_pkg::SRC_MASTER)),
        .i_entry   (in_entry),
        .i_drop    (m_drop),
        .o_entries (m_entries),
        .o_count   (m_count)
    );

    spc_queue #(.DEPTH(QUEUE_DEPTH)) u_slave_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (accept && (s_axis_tuser == spc_pkg::SRC_SLAVE)),
        .i_entry   (in_entry),
        .i_drop    (s_drop),
        .o_entries (s_entries),
        .o_count   (s_count)
    );

    // Oldest slave entry whose index equals the master entry at the scan head.
    always_comb begin
        s_hit = 1'b0;
        s_sel = '0;
        s_tag = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (!s_hit && (CW'(k) < s_count) && (s_entries[k].index == r_scan[0].index)) begin
                s_hit = 1'b1;
                s_sel = SW'(k);
                s_tag = s_entries[k].tag;
            end
        end
    end

    // The period is added back only when the pair index lies below the
    // expected one; the result wraps to 16 bits either way.
    always_comb begin
        expected_wide = {1'b0, r_prev_index} + (IW+1)'(1);
        if (expected_wide >= {1'b0, r_period}) begin
            expected = '0;
        end else begin
            expected = expected_wide[IW-1:0];
        end
        if (!r_prev_valid) begin
            dropped = '0;
        end else if (r_scan[0].index >= expected) begin
            dropped = r_scan[0].index - expected;
        end else begin
            dropped = r_period - expected + r_scan[0].index;
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_period     = r_period;
        n_prev_index = r_prev_index;
        n_prev_valid = r_prev_valid;
        n_m          = r_m;
        n_drop_m     = r_drop_m;
        n_drop_s     = r_drop_s;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_first  = r_out_first;

        if (i_cfg_wr_en) begin
            n_period = i_cfg_wr_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_m     = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_m >= m_count) begin
                    n_state = S_IDLE;
                end else if (s_hit) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_data   = {dropped, r_scan[0].index, s_tag, r_scan[0].tag};
                        n_out_first  = !r_prev_valid;
                        n_prev_index = r_scan[0].index;
                        n_prev_valid = 1'b1;
                        n_drop_m     = r_m + CW'(1);
                        n_drop_s     = CW'(s_sel) + CW'(1);
                        n_state      = S_DROP;
                    end
                end else begin
                    n_m = r_m + CW'(1);
                end
            end
            S_DROP: begin
                if (m_drop) begin
                    n_drop_m = r_drop_m - CW'(1);
                end
                if (s_drop) begin
                    n_drop_s = r_drop_s - CW'(1);
                end
                if ((r_drop_m <= CW'(1)) && (r_drop_s <= CW'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_out_first <= n_out_first;
        r_m         <= n_m;
        r_drop_m    <= n_drop_m;
        r_drop_s    <= n_drop_s;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_period     <= spc_pkg::RESYNC_RESET;
            r_prev_index <= '0;
            r_prev_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_period     <= n_period;
            r_prev_index <= n_prev_index;
            r_prev_valid <= n_prev_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Scan line: loaded from the master row, then moves one cell per cycle
    // toward the head while no slave entry matches.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (r_state == S_LOAD) begin
                r_scan[k] <= m_entries[k];
            end else if ((r_state == S_SCAN) && !s_hit && (k < QUEUE_DEPTH - 1)) begin
                r_scan[k] <= r_scan[(k + 1) % QUEUE_DEPTH];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_first;

endmodule

`default_nettype wire

// ===== rtl/core/spc_cell.sv =====
`default_nettype none

module spc_cell (
    input  wire                 i_clk,
    input  spc_pkg::t_cell_ctl  i_ctl,
    input  spc_pkg::t_entry     i_next,
    input  spc_pkg::t_entry     i_new,
    output spc_pkg::t_entry     o_entry
);

    spc_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end else begin
            r_entry <= r_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== rtl/core/spc_queue.sv =====
`default_nettype none

module spc_queue #(
    parameter int DEPTH = spc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  spc_pkg::t_entry             i_entry,
    input  wire                         i_drop,
    output spc_pkg::t_entry             o_entries [DEPTH],
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                full;
    spc_pkg::t_cell_ctl  ctl   [DEPTH];
    spc_pkg::t_entry     nexts [DEPTH];

    assign full = (r_count == CW'(DEPTH));

    // A push into a full queue moves everything one place toward the head
    // and writes the new frame into the last cell.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            ctl[k].shift = i_drop || (i_push && full);
            if (full) begin
                ctl[k].load = i_push && (k == DEPTH - 1);
            end else begin
                ctl[k].load = i_push && (r_count == CW'(k));
            end
            if (k < DEPTH - 1) begin
                nexts[k] = o_entries[(k + 1) % DEPTH];
            end else begin
                nexts[k] = i_entry;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !full) begin
            n_count = r_count + CW'(1);
        end else if (i_drop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spc_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl[g]),
            .i_next  (nexts[g]),
            .i_new   (i_entry),
            .o_entry (o_entries[g])
        );
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/spc_checker.sv =====
`default_nettype none

module spc_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    input  wire                             s_axis_tready,
    input  wire                             m_axis_tvalid,
    input  wire                             m_axis_tready,
    input  wire  [spc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire                             m_axis_tuser
);

    logic r_seen_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_pair <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_seen_pair <= 1'b1;
        end
    end

    // A stalled result holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Each accepted frame occupies the block for at least the following cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted frame");

    // Only the very first pair after reset carries the first flag.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_seen_pair |-> !m_axis_tuser)
        else $error("first flag on a later pair");

    // The first pair reports no dropped frames.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[47:32] == 16'd0))
        else $error("nonzero drop count on first pair");

endmodule

bind stereo_frame_pairer_unit spc_checker u_spc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
